>>> rtl/core/ttus_pkg.sv
// ----------------------------------------------------------------------------
// ttus_pkg
// Shared types and constants of the truth table unate and support checker.
// ----------------------------------------------------------------------------
package ttus_pkg;

	localparam int MAX_VARS      = 16;
	localparam int VARS_PER_WORD = 6;
	localparam int WORD_W        = 1 << VARS_PER_WORD;
	localparam int ADDR_W        = MAX_VARS - VARS_PER_WORD;
	localparam int STORE_DEPTH   = 1 << ADDR_W;

	localparam int NV_W       = 5;
	localparam int VI_W       = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int LIT_SEL_W  = $clog2(VARS_PER_WORD);

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARS  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_VAR_INDEX = CFG_IDX_W'(1);

	localparam logic [NV_W-1:0] NUM_VARS_RESET  = NV_W'(6);
	localparam logic [VI_W-1:0] VAR_INDEX_RESET = VI_W'(0);

	// positions where the variable is 1, one mask per in-word variable
	localparam logic [WORD_W-1:0] LIT_MASK [VARS_PER_WORD] = '{
		64'hAAAA_AAAA_AAAA_AAAA,
		64'hCCCC_CCCC_CCCC_CCCC,
		64'hF0F0_F0F0_F0F0_F0F0,
		64'hFF00_FF00_FF00_FF00,
		64'hFFFF_0000_FFFF_0000,
		64'hFFFF_FFFF_0000_0000
	};

	typedef struct packed {
		logic [WORD_W-1:0] table_word;
		logic              last_word;
	} in_word_t;

	typedef struct packed {
		logic in_support;
		logic pos_unate;
		logic neg_unate;
		logic var_error;
	} out_word_t;

	// cofactor relations seen so far
	typedef struct packed {
		logic pos_seen;
		logic neg_seen;
		logic binate;
	} obs_t;

endpackage

>>> rtl/core/ttus_store.sv
// ----------------------------------------------------------------------------
// ttus_store
// Word store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ttus_store (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ttus_pkg::ADDR_W-1:0] waddr,
	input  logic [ttus_pkg::WORD_W-1:0] wdata,
	input  logic                        re,
	input  logic [ttus_pkg::ADDR_W-1:0] raddr,
	output logic [ttus_pkg::WORD_W-1:0] rdata
);

	logic [ttus_pkg::WORD_W-1:0] mem_q [ttus_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/ttus_judge.sv
// ----------------------------------------------------------------------------
// ttus_judge
// Compares two cofactors and classifies their order.
// ----------------------------------------------------------------------------
module ttus_judge (
	input  logic                        enable,
	input  logic [ttus_pkg::WORD_W-1:0] f0,
	input  logic [ttus_pkg::WORD_W-1:0] f1,
	output ttus_pkg::obs_t              obs
);

	logic [ttus_pkg::WORD_W-1:0] both;

	assign both = f0 & f1;

	always_comb begin
		obs = '0;
		if (enable && (f0 != f1)) begin
			priority if (both == f0) begin
				obs.pos_seen = 1'b1;
			end else if (both == f1) begin
				obs.neg_seen = 1'b1;
			end else begin
				obs.binate = 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/truth_table_unate_support_check.sv
// ----------------------------------------------------------------------------
// truth_table_unate_support_check
// Support and unateness check of one variable over a streamed truth table.
// ----------------------------------------------------------------------------
// Usage:
//   Configure num_vars (index 0) and var_index (index 1) over the cfg port
//   while idle. Then send the table's 64-bit words in index order on the
//   word channel, the final one with last_word set. Each accepted word is
//   stored at its index; a word whose index has bit (var_index-6) set is
//   compared with its stored partner, a lower variable is checked inside
//   the word itself.
//   One result word follows each last word on the result channel, loaded
//   from the judge stage into the output register.
//   Throughput is one word per cycle while word_ready is high: the store is
//   read at the partner address and written at the current address in the
//   same cycle, and the registered read data meets the word one stage later.
//   When the receiver stalls, the result holds in the output register; the
//   next words keep flowing until a second last word reaches the judge
//   stage, which then holds and drops word_ready.
//   Reset clears the word count, the sticky flags and all valid bits, and
//   loads num_vars = 6, var_index = 0. The store needs no clearing.
// ----------------------------------------------------------------------------
module truth_table_unate_support_check (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ttus_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ttus_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               word_valid,
	output logic                               word_ready,
	input  ttus_pkg::in_word_t                 word_data,
	output logic                               result_valid,
	input  logic                               result_ready,
	output ttus_pkg::out_word_t                result_data
);

	// configuration
	logic [ttus_pkg::NV_W-1:0] num_vars_q;
	logic [ttus_pkg::VI_W-1:0] var_index_q;

	// word count and sticky flags
	logic [ttus_pkg::ADDR_W-1:0] count_q;
	ttus_pkg::obs_t              flags_q;

	// entry stage signals
	logic                              accept;
	logic [ttus_pkg::WORD_W-1:0]       word_mask;
	logic [ttus_pkg::WORD_W-1:0]       word_m;
	logic                              bad;
	logic                              low_var;
	logic [ttus_pkg::LIT_SEL_W-1:0]    lit_sel;
	logic [ttus_pkg::WORD_W-1:0]       lit_m;
	logic [6:0]                        half_sh;
	logic [ttus_pkg::WORD_W-1:0]       p0;
	logic [ttus_pkg::WORD_W-1:0]       p1;
	logic [ttus_pkg::ADDR_W-1:0]       bit_sel;
	logic [ttus_pkg::ADDR_W-1:0]       partner;
	logic                              check;

	// judge stage
	logic                        valid_s1;
	logic                        last_s1;
	logic                        bad_s1;
	logic                        check_s1;
	logic                        low_s1;
	logic [ttus_pkg::WORD_W-1:0] f0lo_s1;
	logic [ttus_pkg::WORD_W-1:0] f1_s1;
	logic [ttus_pkg::WORD_W-1:0] store_rdata;
	logic [ttus_pkg::WORD_W-1:0] f0;
	logic                        s1_move;
	logic                        load_result;
	ttus_pkg::obs_t              obs;
	ttus_pkg::obs_t              flags_sum;

	// configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vars_q  <= ttus_pkg::NUM_VARS_RESET;
			var_index_q <= ttus_pkg::VAR_INDEX_RESET;
		end else if (cfg_we) begin
			if (cfg_index == ttus_pkg::CFG_NUM_VARS) begin
				num_vars_q <= cfg_data[ttus_pkg::NV_W-1:0];
			end
			if (cfg_index == ttus_pkg::CFG_VAR_INDEX) begin
				var_index_q <= cfg_data[ttus_pkg::VI_W-1:0];
			end
		end
	end

	// the judge stage advances unless it holds a result and the output is full
	assign s1_move     = !valid_s1 || !last_s1 || !result_valid || result_ready;
	assign word_ready  = s1_move;
	assign accept      = word_valid && word_ready;
	assign load_result = valid_s1 && last_s1 && s1_move;

	// entry stage: mask a small table, split the cofactors of an in-word variable
	always_comb begin
		if (num_vars_q < ttus_pkg::NV_W'(ttus_pkg::VARS_PER_WORD)) begin
			word_mask = ~({ttus_pkg::WORD_W{1'b1}} << (7'd1 << num_vars_q[2:0]));
		end else begin
			word_mask = {ttus_pkg::WORD_W{1'b1}};
		end
		word_m = word_data.table_word & word_mask;

		bad = ({1'b0, var_index_q} >= num_vars_q) ||
		      ({1'b0, var_index_q} >= ttus_pkg::NV_W'(ttus_pkg::MAX_VARS));
		low_var = var_index_q < ttus_pkg::VI_W'(ttus_pkg::VARS_PER_WORD);

		lit_sel = low_var ? var_index_q[ttus_pkg::LIT_SEL_W-1:0] : '0;
		lit_m   = ttus_pkg::LIT_MASK[lit_sel];
		half_sh = 7'd1 << lit_sel;
		p0      = word_m & ~lit_m;
		p1      = word_m & lit_m;
		p0      = p0 | (p0 << half_sh);
		p1      = p1 | (p1 >> half_sh);

		// partner of a higher variable sits at the index with that bit clear
		bit_sel = ttus_pkg::ADDR_W'(1) <<
		          (var_index_q - ttus_pkg::VI_W'(ttus_pkg::VARS_PER_WORD));
		partner = count_q ^ bit_sel;
		check   = !bad && (low_var || ((count_q & bit_sel) != '0));
	end

	ttus_store u_store (
		.clk   (clk),
		.we    (accept),
		.waddr (count_q),
		.wdata (word_m),
		.re    (accept),
		.raddr (partner),
		.rdata (store_rdata)
	);

	// advance the word count, restart after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= word_data.last_word ? '0 : count_q + ttus_pkg::ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_move) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1  <= word_data.last_word;
			bad_s1   <= bad;
			check_s1 <= check;
			low_s1   <= low_var;
			f0lo_s1  <= p0;
			f1_s1    <= low_var ? p1 : word_m;
		end
	end

	// judge stage: for a higher variable the partner word from the store is cofactor 0
	assign f0 = low_s1 ? f0lo_s1 : store_rdata;

	ttus_judge u_judge (
		.enable (check_s1),
		.f0     (f0),
		.f1     (f1_s1),
		.obs    (obs)
	);

	assign flags_sum = flags_q | obs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (valid_s1 && s1_move) begin
			flags_q <= last_s1 ? '0 : flags_sum;
		end
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load_result) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			if (bad_s1) begin
				result_data <= '{in_support: 1'b0, pos_unate: 1'b0,
				                 neg_unate: 1'b0, var_error: 1'b1};
			end else begin
				result_data.in_support <= flags_sum.pos_seen || flags_sum.neg_seen ||
				                          flags_sum.binate;
				result_data.pos_unate  <= !flags_sum.binate && !flags_sum.neg_seen;
				result_data.neg_unate  <= !flags_sum.binate && !flags_sum.pos_seen;
				result_data.var_error  <= 1'b0;
			end
		end
	end

endmodule

>>> sim/ttus_unate_checker.sv
// ----------------------------------------------------------------------------
// ttus_unate_checker
// Watches the word, result and cfg ports of the unate and support checker,
// folds each accepted table word into its own support and unateness flags,
// and compares every result word against the oldest predicted verdict.
// ----------------------------------------------------------------------------
module ttus_unate_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ttus_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ttus_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             word_valid,
	input  logic                             word_ready,
	input  ttus_pkg::in_word_t               word_data,
	input  logic                             result_valid,
	input  logic                             result_ready,
	input  ttus_pkg::out_word_t              result_data,
	output int                               fail_count,
	output int                               pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [ttus_pkg::NV_W-1:0]   num_vars_q;
	logic [ttus_pkg::VI_W-1:0]   var_index_q;
	logic [ttus_pkg::WORD_W-1:0] table_copy [ttus_pkg::STORE_DEPTH];
	logic [ttus_pkg::ADDR_W-1:0] word_pos;
	logic                        saw_pos;
	logic                        saw_neg;
	logic                        saw_binate;
	ttus_pkg::out_word_t         verdict_q [$];
	int                          mismatches = 0;

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// f0 is the cofactor with the variable at 0, f1 with it at 1
	function automatic void note_cofactors(logic [ttus_pkg::WORD_W-1:0] f0,
	                                       logic [ttus_pkg::WORD_W-1:0] f1);
		if (f0 != f1) begin
			if ((f0 & ~f1) == '0)
				saw_pos = 1'b1;
			else if ((f1 & ~f0) == '0)
				saw_neg = 1'b1;
			else
				saw_binate = 1'b1;
		end
	endfunction

	// fold one table word into the flags; queue a verdict on the last word
	function automatic void fold_table_word(ttus_pkg::in_word_t item);
		logic [ttus_pkg::WORD_W-1:0] w;
		logic [ttus_pkg::WORD_W-1:0] c0;
		logic [ttus_pkg::WORD_W-1:0] c1;
		logic [ttus_pkg::ADDR_W-1:0] step;
		logic                        bad;
		ttus_pkg::out_word_t         v;
		int                          j;
		int                          k;
		w = item.table_word;
		bad = (var_index_q >= num_vars_q);
		if (num_vars_q < ttus_pkg::VARS_PER_WORD)
			w = w & ((64'd1 << (1 << num_vars_q)) - 64'd1);
		if (!bad) begin
			if (var_index_q < ttus_pkg::VARS_PER_WORD) begin
				// gather the two halves bit by bit, pairing k with k + 2^var
				c0 = '0;
				c1 = '0;
				j = 0;
				for (k = 0; k < ttus_pkg::WORD_W; k++) begin
					if (((k >> var_index_q) & 1) == 0) begin
						c0[j] = w[k];
						c1[j] = w[k + (1 << var_index_q)];
						j++;
					end
				end
				note_cofactors(c0, c1);
			end else begin
				step = ttus_pkg::ADDR_W'(1) << (var_index_q - ttus_pkg::VARS_PER_WORD);
				if ((word_pos & step) != '0)
					note_cofactors(table_copy[word_pos ^ step], w);
			end
		end
		table_copy[word_pos] = w;
		word_pos = word_pos + 1'b1;
		if (item.last_word) begin
			v = '0;
			if (bad) begin
				v.var_error = 1'b1;
			end else begin
				v.in_support = saw_pos | saw_neg | saw_binate;
				v.pos_unate  = !saw_binate && !saw_neg;
				v.neg_unate  = !saw_binate && !saw_pos;
			end
			verdict_q.push_back(v);
			word_pos = '0;
			saw_pos = 1'b0;
			saw_neg = 1'b0;
			saw_binate = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ttus_pkg::out_word_t want;
		if (!arst_n) begin
			num_vars_q = ttus_pkg::NUM_VARS_RESET;
			var_index_q = ttus_pkg::VAR_INDEX_RESET;
			word_pos = '0;
			saw_pos = 1'b0;
			saw_neg = 1'b0;
			saw_binate = 1'b0;
			verdict_q.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch($sformatf("result %b with no verdict waiting", result_data));
				end else begin
					want = verdict_q.pop_front();
					if (result_data.in_support !== want.in_support)
						report_mismatch($sformatf("in_support %b, want %b",
							result_data.in_support, want.in_support));
					if (result_data.pos_unate !== want.pos_unate)
						report_mismatch($sformatf("pos_unate %b, want %b",
							result_data.pos_unate, want.pos_unate));
					if (result_data.neg_unate !== want.neg_unate)
						report_mismatch($sformatf("neg_unate %b, want %b",
							result_data.neg_unate, want.neg_unate));
					if (result_data.var_error !== want.var_error)
						report_mismatch($sformatf("var_error %b, want %b",
							result_data.var_error, want.var_error));
				end
			end
			// a word at this edge still sees the old register values
			if (word_valid && word_ready)
				fold_table_word(word_data);
			if (cfg_we) begin
				if (cfg_index == ttus_pkg::CFG_NUM_VARS)
					num_vars_q = cfg_data[ttus_pkg::NV_W-1:0];
				else if (cfg_index == ttus_pkg::CFG_VAR_INDEX)
					var_index_q = cfg_data[ttus_pkg::VI_W-1:0];
			end
		end
		fail_count <= mismatches;
		pending_results <= verdict_q.size();
	end

endmodule

>>> sim/tb_truth_table_unate_support_check.sv
// ----------------------------------------------------------------------------
// tb_truth_table_unate_support_check
// Drives truth tables through the unate and support checker and judges it.
// A short directed set hits the classic functions, the bad variable index,
// tables smaller than one word and the largest settings; then random tables,
// free or shaped to be flat, positive, negative or mixed in the chosen variable,
// run under three idling patterns, closing with one table that wraps the store.
// The side checker predicts every verdict; this module only makes stimulus.
// ----------------------------------------------------------------------------
module tb_truth_table_unate_support_check;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 540;
	localparam int QUIET_CYCLES = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;

	// how the words of one table relate across the chosen variable
	typedef enum int {
		SHAPE_FREE,
		SHAPE_FLAT,
		SHAPE_POS,
		SHAPE_NEG,
		SHAPE_MIX
	} shape_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [ttus_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ttus_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            word_valid;
	logic                            word_ready;
	ttus_pkg::in_word_t              word_data;
	logic                            result_valid;
	logic                            result_ready;
	ttus_pkg::out_word_t             result_data;

	int fail_count;
	int pending_results;
	int cycle_count   = 0;
	int send_idle_pct = 7;
	int recv_idle_pct = 52;
	int sent_items    = 0;

	// words of the table in flight, so partner words can be derived
	logic [ttus_pkg::WORD_W-1:0] sent_words [ttus_pkg::STORE_DEPTH];

	truth_table_unate_support_check dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.word_valid   (word_valid),
		.word_ready   (word_ready),
		.word_data    (word_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

	ttus_unate_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.word_valid      (word_valid),
		.word_ready      (word_ready),
		.word_data       (word_data),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result_data     (result_data),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// stall the result side at random, at the current idling rate
	initial result_ready = 1'b0;
	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= recv_idle_pct);

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// offer one word, with random idle gaps first; return at its acceptance
	// so that the next word can follow in the same step without a dip
	task automatic push_word(logic [ttus_pkg::WORD_W-1:0] bits, logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			word_valid <= 1'b0;
			@(posedge clk);
		end
		word_valid <= 1'b1;
		word_data <= '{table_word: bits, last_word: fin};
		@(posedge clk);
		while (!word_ready)
			@(posedge clk);
		sent_items++;
	endtask

	// drop valid and wait until every verdict is in and the pipe is quiet
	task automatic settle(int extra);
		word_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (extra)
			@(posedge clk);
	endtask

	// write both registers once the block is idle
	task automatic set_config(int nv, int vi);
		settle(QUIET_CYCLES);
		cfg_we <= 1'b1;
		cfg_index <= ttus_pkg::CFG_NUM_VARS;
		cfg_data <= ttus_pkg::CFG_DATA_W'(nv);
		@(posedge clk);
		cfg_index <= ttus_pkg::CFG_VAR_INDEX;
		cfg_data <= ttus_pkg::CFG_DATA_W'(vi);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// send one table of len words, shaped in variable vi
	task automatic send_table(int nv, int vi, int len, shape_t s);
		logic [ttus_pkg::WORD_W-1:0] hi_mask;
		logic [ttus_pkg::WORD_W-1:0] lo_half;
		logic [ttus_pkg::WORD_W-1:0] r1;
		logic [ttus_pkg::WORD_W-1:0] r2;
		logic [ttus_pkg::WORD_W-1:0] bits;
		shape_t                      pick;
		int                          w;
		int                          k;
		int                          span;
		// positions where an in-word variable is 1
		hi_mask = '0;
		for (k = 0; k < ttus_pkg::WORD_W; k++)
			hi_mask[k] = ((k >> vi) & 1) != 0;
		span = (vi >= ttus_pkg::VARS_PER_WORD) ? (1 << (vi - ttus_pkg::VARS_PER_WORD)) : 0;
		for (w = 0; w < len; w++) begin
			r1 = {$urandom, $urandom};
			// sparse flips, so unate words often keep equal halves
			r2 = {$urandom, $urandom} & {$urandom, $urandom};
			pick = s;
			if (s == SHAPE_MIX)
				pick = $urandom_range(1) ? SHAPE_POS : SHAPE_NEG;
			bits = r1;
			if (vi < nv && pick != SHAPE_FREE) begin
				if (vi < ttus_pkg::VARS_PER_WORD) begin
					// copy the low half up, then grow or shrink the high half
					lo_half = r1 & ~hi_mask;
					bits = lo_half | (lo_half << (1 << vi));
					if (pick == SHAPE_POS)
						bits |= r2 & hi_mask;
					else if (pick == SHAPE_NEG)
						bits &= ~(r2 & hi_mask);
				end else if ((w & span) != 0) begin
					// derive from the partner word sent earlier in this table
					bits = sent_words[(w ^ span) % ttus_pkg::STORE_DEPTH];
					if (pick == SHAPE_POS)
						bits |= r2;
					else if (pick == SHAPE_NEG)
						bits &= ~r2;
				end
			end
			// junk above a small table must be ignored by the block
			if (nv < ttus_pkg::VARS_PER_WORD)
				bits |= {$urandom, $urandom} & ~((64'd1 << (1 << nv)) - 64'd1);
			sent_words[w % ttus_pkg::STORE_DEPTH] = bits;
			push_word(bits, w == len - 1);
		end
	endtask

	initial begin
		int nv;
		int vi;
		int len;
		int span;
		int rand_start;
		int done;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		word_valid <= 1'b0;
		word_data <= '0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;

		// ---- directed words ----
		// reset values, single-word tables: constant, x0, !x0, x0^x1, zero
		set_config(6, 0);
		push_word('1, 1'b1);
		push_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		push_word(64'h5555_5555_5555_5555, 1'b1);
		push_word(64'h6666_6666_6666_6666, 1'b1);
		push_word('0, 1'b1);
		// no variables at all: any index is bad
		set_config(0, 0);
		push_word('1, 1'b1);
		// widest setting, top variable, one word only
		set_config(16, 15);
		push_word({$urandom, $urandom}, 1'b1);
		// tiny tables with ones above the valid minterms
		set_config(1, 0);
		push_word(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
		set_config(5, 4);
		push_word(64'hFFFF_FFFF_FFFF_0000, 1'b1);
		// variable across words: positive, then negative
		set_config(7, 6);
		push_word('0, 1'b0);
		push_word('1, 1'b1);
		push_word('1, 1'b0);
		push_word('0, 1'b1);
		// positive pair and negative pair in one table: binate
		set_config(8, 7);
		push_word(64'h0000_0000_0000_00FF, 1'b0);
		push_word(64'h0000_0000_0000_FF00, 1'b0);
		push_word(64'h0000_0000_0000_0FFF, 1'b0);
		push_word(64'h0000_0000_0000_F000, 1'b1);
		// highest in-word variable
		set_config(6, 5);
		push_word(64'hFFFF_FFFF_0000_0000, 1'b1);
		// index equal to the variable count
		set_config(3, 3);
		push_word({$urandom, $urandom}, 1'b1);

		// ---- random tables ----
		rand_start = sent_items;
		while (sent_items - rand_start < RANDOM_ITEMS) begin
			done = sent_items - rand_start;
			if (done < RANDOM_ITEMS / 3) begin
				send_idle_pct <= 7;
				recv_idle_pct <= 52;
			end else if (done < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct <= 52;
				recv_idle_pct <= 7;
			end else begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
			end

			// favor small tables, visit the big ones now and then
			case ($urandom_range(9))
				0, 1, 2, 3: nv = $urandom_range(0, 6);
				4, 5, 6, 7: nv = $urandom_range(7, 11);
				8:          nv = $urandom_range(12, 16);
				default:    nv = $urandom_range(1) ? 0 : 16;
			endcase
			if (nv == 0 || $urandom_range(7) == 0)
				vi = $urandom_range(0, 15);
			else
				vi = $urandom_range(0, nv - 1);
			set_config(nv, vi);

			repeat ($urandom_range(1, 5)) begin
				// cover the partner span of a high variable where affordable
				if (vi >= ttus_pkg::VARS_PER_WORD && vi < nv) begin
					span = 2 << (vi - ttus_pkg::VARS_PER_WORD);
					if (span <= 64)
						len = ($urandom_range(3) == 0) ? $urandom_range(1, span) : span;
					else if (span <= 256 && $urandom_range(3) == 0)
						len = span;
					else
						len = $urandom_range(1, 48);
				end else if (nv > ttus_pkg::VARS_PER_WORD) begin
					len = $urandom_range(1,
						(nv > 8) ? 12 : (1 << (nv - ttus_pkg::VARS_PER_WORD)));
				end else begin
					len = $urandom_range(1, 3);
				end
				send_table(nv, vi, len, shape_t'($urandom_range(4)));
			end
		end

		// one full-depth table that runs past the end of the store
		set_config(16, 15);
		send_table(16, 15, ttus_pkg::STORE_DEPTH + 20, shape_t'($urandom_range(1, 4)));

		// drain and judge
		settle(DRAIN_CYCLES);
		if (fail_count == 0 && pending_results == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
